// File: src/wfsa_pkg.sv
// Shared types, codes and sizes of the worst-fit segment allocator.
package wfsa_pkg;

	localparam int NUM_SEGS = 16;
	localparam int IDX_W = $clog2(NUM_SEGS);
	localparam int ADDR_W = 16;
	localparam int ID_W = 16;
	localparam logic [ADDR_W-1:0] MEM_SIZE_RST = ADDR_W'(1024);

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_LIST  = 2'd2,
		OP_RSVD  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		STAT_ALLOC     = 3'd0,
		STAT_NO_SPACE  = 3'd1,
		STAT_FREED     = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_LIST      = 3'd4,
		STAT_FULL      = 3'd5,
		STAT_ZERO      = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_QUICK,
		S_SCAN,
		S_EVAL,
		S_HOLE,
		S_SEG,
		S_TAIL,
		S_FREE,
		S_FIN
	} fsm_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic scan_step;
		logic emit_hole;
		logic emit_seg;
		logic emit_tail;
		logic free_step;
		logic quick;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		opcode_t op;
		logic    quick_fail;
		logic    scan_last;
		logic    found;
		logic    gap;
		logic    tail;
		logic    can_push;
		logic    out_space;
		logic    pend_busy;
	} sts_t;

endpackage

// File: src/wfsa_ctrl.sv
// Request sequencer of the worst-fit segment allocator.
module wfsa_ctrl import wfsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	fsm_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISP;
			end
			S_DISP: begin
				unique case (sts.op)
					OP_ALLOC: state_d = sts.quick_fail ? S_QUICK : S_SCAN;
					OP_FREE:  state_d = S_FREE;
					OP_LIST:  state_d = S_SCAN;
					default:  state_d = S_IDLE;
				endcase
			end
			S_QUICK: begin
				if (sts.out_space) state_d = S_IDLE;
			end
			S_SCAN: begin
				if (sts.scan_last) state_d = S_EVAL;
			end
			S_EVAL: begin
				if (sts.found) state_d = sts.gap ? S_HOLE : S_SEG;
				else state_d = sts.tail ? S_TAIL : S_FIN;
			end
			S_HOLE: begin
				if (sts.can_push) state_d = S_SEG;
			end
			S_SEG: begin
				if (sts.can_push) state_d = S_SCAN;
			end
			S_TAIL: begin
				if (sts.can_push) state_d = S_FIN;
			end
			S_FREE: begin
				if (sts.can_push && sts.scan_last) state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_space) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_QUICK: cmd.quick = sts.out_space;
			S_SCAN:  cmd.scan_step = 1'b1;
			S_HOLE:  cmd.emit_hole = sts.can_push;
			S_SEG:   cmd.emit_seg = sts.can_push;
			S_TAIL:  cmd.emit_tail = sts.can_push;
			S_FREE:  cmd.free_step = sts.can_push;
			S_FIN:   cmd.finish = sts.out_space;
			default: cmd = '0;
		endcase
	end

endmodule

// File: src/wfsa_dp.sv
// Segment table, address-order walk and result registers of the allocator.
module wfsa_dp import wfsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        opcode,
	input  logic [ID_W-1:0]   owner_id,
	input  logic [ADDR_W-1:0] request_size,
	input  logic              cfg_wr_en,
	input  logic [ADDR_W-1:0] cfg_wr_data,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [2:0]        status,
	output logic [ADDR_W-1:0] address,
	output logic [ADDR_W-1:0] length,
	output logic [ID_W-1:0]   result_owner,
	output logic              is_hole,
	output logic              last
);

	// Segment table
	logic [ADDR_W-1:0]   mem_size_q;
	logic [NUM_SEGS-1:0] valid_q;
	logic [ID_W-1:0]     own_q   [NUM_SEGS];
	logic [ADDR_W-1:0]   start_q [NUM_SEGS];
	logic [ADDR_W-1:0]   len_q   [NUM_SEGS];

	// Request and walk state
	opcode_t           op_q;
	logic [ID_W-1:0]   id_q;
	logic [ADDR_W-1:0] size_q;
	logic [IDX_W-1:0]  scan_q;
	logic              found_q, have_prev_q;
	logic [ADDR_W-1:0] prev_start_q, cand_start_q, cand_len_q;
	logic [IDX_W-1:0]  prev_idx_q, cand_idx_q;
	logic [ID_W-1:0]   cand_own_q;
	logic [ADDR_W:0]   cursor_q;
	logic [ADDR_W-1:0] best_len_q, best_start_q;

	// Pending item and output register
	logic              pend_valid_q;
	status_t           pend_stat_q, out_stat_q;
	logic [ADDR_W-1:0] pend_addr_q, pend_len_q, out_addr_q, out_len_q;
	logic [ID_W-1:0]   pend_own_q, out_own_q;
	logic              pend_hole_q, out_hole_q, out_last_q, out_valid_q;

	logic              rd_valid, take, free_hit, gap, tail, full, out_space, is_alloc;
	logic [ADDR_W-1:0] rd_start, rd_len, gap_len, tail_len;
	logic [ID_W-1:0]   rd_own;
	logic [ADDR_W:0]   seg_end;
	logic [IDX_W-1:0]  slot, scan_nxt;
	logic              push_en, hole_new, new_len_big;
	status_t           p_stat;
	logic [ADDR_W-1:0] p_addr, p_len;
	logic [ID_W-1:0]   p_own;
	logic              p_hole;
	logic              o_wr, o_last;
	status_t           o_stat;
	logic [ADDR_W-1:0] o_addr, o_len;
	logic [ID_W-1:0]   o_own;
	logic              o_hole;

	// Read the entry under the scan index
	assign rd_valid = valid_q[scan_q];
	assign rd_start = start_q[scan_q];
	assign rd_len   = len_q[scan_q];
	assign rd_own   = own_q[scan_q];

	// Next segment in address order: above the previous key, below the candidate
	assign take = rd_valid
		&& (!have_prev_q || {rd_start, scan_q} > {prev_start_q, prev_idx_q})
		&& (!found_q || {rd_start, scan_q} < {cand_start_q, cand_idx_q});
	assign free_hit = rd_valid && (rd_own == id_q);
	assign scan_nxt = (scan_q == IDX_W'(NUM_SEGS - 1)) ? '0 : scan_q + 1'b1;

	assign seg_end  = {1'b0, cand_start_q} + {1'b0, cand_len_q};
	assign gap      = {1'b0, cand_start_q} > cursor_q;
	assign gap_len  = cand_start_q - cursor_q[ADDR_W-1:0];
	assign tail     = {1'b0, mem_size_q} > cursor_q;
	assign tail_len = mem_size_q - cursor_q[ADDR_W-1:0];

	// Lowest free table entry
	always_comb begin
		slot = '0;
		for (int i = NUM_SEGS - 1; i >= 0; i--) begin
			if (!valid_q[i]) slot = IDX_W'(i);
		end
	end
	assign full = &valid_q;

	assign is_alloc  = (op_q == OP_ALLOC);
	assign out_space = !out_valid_q || !out_stall;

	// Item produced by the walk or the free scan
	always_comb begin
		p_stat   = STAT_LIST;
		p_addr   = cursor_q[ADDR_W-1:0];
		p_len    = gap_len;
		p_own    = '0;
		p_hole   = 1'b1;
		hole_new = 1'b0;
		if (cmd.emit_hole) begin
			hole_new = 1'b1;
		end else if (cmd.emit_tail) begin
			p_len    = tail_len;
			hole_new = 1'b1;
		end else if (cmd.emit_seg) begin
			p_addr = cand_start_q;
			p_len  = cand_len_q;
			p_own  = cand_own_q;
			p_hole = 1'b0;
		end else begin
			p_stat = STAT_FREED;
			p_addr = rd_start;
			p_len  = rd_len;
			p_own  = id_q;
			p_hole = 1'b0;
		end
	end
	assign push_en = !is_alloc && (cmd.emit_hole || cmd.emit_tail || cmd.emit_seg
		|| (cmd.free_step && free_hit));
	assign new_len_big = hole_new && (p_len > best_len_q);

	// Result going to the output register
	always_comb begin
		o_wr   = 1'b0;
		o_stat = STAT_LIST;
		o_addr = '0;
		o_len  = '0;
		o_own  = id_q;
		o_hole = 1'b0;
		o_last = 1'b1;
		if (cmd.quick) begin
			o_wr   = 1'b1;
			o_stat = (size_q == '0) ? STAT_ZERO : STAT_FULL;
			o_len  = (size_q == '0) ? '0 : size_q;
		end else if (cmd.finish) begin
			o_wr = 1'b1;
			if (is_alloc) begin
				if (best_len_q >= size_q) begin
					o_stat = STAT_ALLOC;
					o_addr = best_start_q;
				end else begin
					o_stat = STAT_NO_SPACE;
				end
				o_len = size_q;
			end else if (pend_valid_q) begin
				o_stat = pend_stat_q;
				o_addr = pend_addr_q;
				o_len  = pend_len_q;
				o_own  = pend_own_q;
				o_hole = pend_hole_q;
			end else if (op_q == OP_FREE) begin
				o_stat = STAT_NOT_FOUND;
			end else begin
				o_own  = '0;
				o_hole = 1'b1;
			end
		end else if (push_en && pend_valid_q) begin
			o_wr   = 1'b1;
			o_stat = pend_stat_q;
			o_addr = pend_addr_q;
			o_len  = pend_len_q;
			o_own  = pend_own_q;
			o_hole = pend_hole_q;
			o_last = 1'b0;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= MEM_SIZE_RST;
		end else if (cfg_wr_en) begin
			mem_size_q <= cfg_wr_data;
		end
	end

	// Valid bits: set on allocation, drop on free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.finish && is_alloc && (best_len_q >= size_q)) begin
			valid_q[slot] <= 1'b1;
		end else if (cmd.free_step && free_hit) begin
			valid_q[scan_q] <= 1'b0;
		end
	end

	// Table payload
	always_ff @(posedge clk) begin
		if (cmd.finish && is_alloc && (best_len_q >= size_q)) begin
			own_q[slot]   <= id_q;
			start_q[slot] <= best_start_q;
			len_q[slot]   <= size_q;
		end
	end

	// Walk control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			found_q      <= 1'b0;
			have_prev_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_q      <= '0;
				found_q     <= 1'b0;
				have_prev_q <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_q <= scan_nxt;
				if (take) found_q <= 1'b1;
			end else if (cmd.emit_seg) begin
				scan_q      <= '0;
				found_q     <= 1'b0;
				have_prev_q <= 1'b1;
			end else if (cmd.free_step) begin
				scan_q <= scan_nxt;
			end
			if (cmd.finish) pend_valid_q <= 1'b0;
			else if (push_en) pend_valid_q <= 1'b1;
			if (o_wr) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Walk payload: request, candidate, cursor and best hole
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= opcode_t'(opcode);
			id_q       <= owner_id;
			size_q     <= request_size;
			cursor_q   <= '0;
			best_len_q <= '0;
		end
		if (cmd.scan_step && take) begin
			cand_start_q <= rd_start;
			cand_len_q   <= rd_len;
			cand_own_q   <= rd_own;
			cand_idx_q   <= scan_q;
		end
		if (cmd.emit_seg) begin
			prev_start_q <= cand_start_q;
			prev_idx_q   <= cand_idx_q;
			if (seg_end > cursor_q) cursor_q <= seg_end;
		end
		if (is_alloc && new_len_big) begin
			best_len_q   <= p_len;
			best_start_q <= p_addr;
		end
		if (push_en) begin
			pend_stat_q <= p_stat;
			pend_addr_q <= p_addr;
			pend_len_q  <= p_len;
			pend_own_q  <= p_own;
			pend_hole_q <= p_hole;
		end
		if (o_wr) begin
			out_stat_q <= o_stat;
			out_addr_q <= o_addr;
			out_len_q  <= o_len;
			out_own_q  <= o_own;
			out_hole_q <= o_hole;
			out_last_q <= o_last;
		end
	end

	// Status to the controller
	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.quick_fail = (size_q == '0) || full;
		sts.scan_last  = (scan_q == IDX_W'(NUM_SEGS - 1));
		sts.found      = found_q;
		sts.gap        = gap;
		sts.tail       = tail;
		sts.can_push   = is_alloc || !pend_valid_q || out_space;
		sts.out_space  = out_space;
		sts.pend_busy  = pend_valid_q;
	end

	assign out_valid    = out_valid_q;
	assign status       = out_stat_q;
	assign address      = out_addr_q;
	assign length       = out_len_q;
	assign result_owner = out_own_q;
	assign is_hole      = out_hole_q;
	assign last         = out_last_q;

endmodule

// File: src/worst_fit_segment_allocator.sv
// Worst-fit allocator over a table of 16 segments; one request at a time.
// Requests are processed one at a time: in_stall stays high from the transfer
// until the last result is in the output register. The table is walked in
// address order by a scan that visits one entry per clock; each step of the
// walk is a full scan of the table, an evaluate state and a state that takes
// the segment, with a hole state ahead of it where a gap lies before it.
// Allocate and list end with a tail hole if memory remains; in a list the
// hole, segment and tail states wait while the receiver stalls. Free makes a
// single pass over the table; zero-size and table-full allocations skip the walk.
// Results are held one deep so that the final item can carry last.
module worst_fit_segment_allocator import wfsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [ID_W-1:0]   owner_id,
	input  logic [ADDR_W-1:0] request_size,
	input  logic              cfg_wr_en,
	input  logic [ADDR_W-1:0] cfg_wr_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [ADDR_W-1:0] address,
	output logic [ADDR_W-1:0] length,
	output logic [ID_W-1:0]   result_owner,
	output logic              is_hole,
	output logic              last
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	wfsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Table and result path
	wfsa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.opcode       (opcode),
		.owner_id     (owner_id),
		.request_size (request_size),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.sts          (sts),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.address      (address),
		.length       (length),
		.result_owner (result_owner),
		.is_hole      (is_hole),
		.last         (last)
	);

`ifndef SYNTHESIS
	// A new request never finds a result still held back
	a_pend_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !sts.pend_busy)
		else $error("request accepted with a pending result");

	// Final results only go where the output register is free or leaving
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish || cmd.quick) |-> sts.out_space)
		else $error("final result overwrites a waiting transfer");

	// A segment is emitted only after the scan found one
	a_seg_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_seg |-> sts.found)
		else $error("segment emitted without a candidate");
`endif

endmodule

// File: tb/wfsa_checker.sv
// Checker for the worst-fit segment allocator: tracks the segment table and compares results.
module wfsa_checker import wfsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [ID_W-1:0]   owner_id,
	input  logic [ADDR_W-1:0] request_size,
	input  logic              cfg_wr_en,
	input  logic [ADDR_W-1:0] cfg_wr_data,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [2:0]        status,
	input  logic [ADDR_W-1:0] address,
	input  logic [ADDR_W-1:0] length,
	input  logic [ID_W-1:0]   result_owner,
	input  logic              is_hole,
	input  logic              last,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t           st;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] len;
		logic [ID_W-1:0]   own;
		logic              hole;
		logic              fin;
	} alloc_result_t;

	// Model copy of the segment table and the size register
	logic [ADDR_W-1:0] mem_size;
	logic              tbl_valid [NUM_SEGS];
	logic [ID_W-1:0]   tbl_owner [NUM_SEGS];
	logic [ADDR_W-1:0] tbl_start [NUM_SEGS];
	logic [ADDR_W-1:0] tbl_len [NUM_SEGS];

	// Address-ordered map of segments and holes
	int unsigned map_start [2*NUM_SEGS+1];
	int unsigned map_len [2*NUM_SEGS+1];
	logic [ID_W-1:0] map_own [2*NUM_SEGS+1];
	logic map_hole [2*NUM_SEGS+1];

	alloc_result_t results_due[$];

	assign pending = results_due.size();

	function automatic void push_result(status_t st, int unsigned a, int unsigned l,
			logic [ID_W-1:0] own, logic hole, logic fin);
		alloc_result_t r;
		r.st = st;
		r.addr = a[ADDR_W-1:0];
		r.len = l[ADDR_W-1:0];
		r.own = own;
		r.hole = hole;
		r.fin = fin;
		results_due.insert(results_due.size(), r);
	endfunction

	// Sort live entries by start, then walk them with a cursor at the highest end seen
	function automatic int build_layout();
		int order [NUM_SEGS];
		int n;
		int cnt;
		int j;
		int s;
		int unsigned cursor;
		int unsigned seg_end;
		n = 0;
		cnt = 0;
		cursor = 0;
		for (int i = 0; i < NUM_SEGS; i++) begin
			if (tbl_valid[i]) begin
				j = n;
				while (j > 0 && tbl_start[order[j-1]] > tbl_start[i]) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = i;
				n++;
			end
		end
		for (int i = 0; i < n; i++) begin
			s = order[i];
			seg_end = int'(tbl_start[s]) + int'(tbl_len[s]);
			if (tbl_start[s] > cursor) begin
				map_start[cnt] = cursor;
				map_len[cnt] = tbl_start[s] - cursor;
				map_own[cnt] = '0;
				map_hole[cnt] = 1'b1;
				cnt++;
			end
			map_start[cnt] = tbl_start[s];
			map_len[cnt] = tbl_len[s];
			map_own[cnt] = tbl_owner[s];
			map_hole[cnt] = 1'b0;
			cnt++;
			if (seg_end > cursor)
				cursor = seg_end;
		end
		if (mem_size > cursor) begin
			map_start[cnt] = cursor;
			map_len[cnt] = mem_size - cursor;
			map_own[cnt] = '0;
			map_hole[cnt] = 1'b1;
			cnt++;
		end
		return cnt;
	endfunction

	// Apply one request to the table and queue the results it causes
	function automatic void predict_request(opcode_t op, logic [ID_W-1:0] id,
			logic [ADDR_W-1:0] sz);
		int slot;
		int cnt;
		int k;
		int unsigned best;
		int unsigned best_start;
		case (op)
			OP_ALLOC: begin
				slot = -1;
				best = 0;
				best_start = 0;
				if (sz == 0) begin
					push_result(STAT_ZERO, 0, 0, id, 1'b0, 1'b1);
					return;
				end
				for (int i = NUM_SEGS - 1; i >= 0; i--)
					if (!tbl_valid[i])
						slot = i;
				if (slot < 0) begin
					push_result(STAT_FULL, 0, sz, id, 1'b0, 1'b1);
					return;
				end
				cnt = build_layout();
				for (int i = 0; i < cnt; i++)
					if (map_hole[i] && map_len[i] > best) begin
						best = map_len[i];
						best_start = map_start[i];
					end
				if (best < sz) begin
					push_result(STAT_NO_SPACE, 0, sz, id, 1'b0, 1'b1);
					return;
				end
				tbl_valid[slot] = 1'b1;
				tbl_owner[slot] = id;
				tbl_start[slot] = best_start[ADDR_W-1:0];
				tbl_len[slot] = sz;
				push_result(STAT_ALLOC, best_start, sz, id, 1'b0, 1'b1);
			end
			OP_FREE: begin
				k = 0;
				for (int i = 0; i < NUM_SEGS; i++)
					if (tbl_valid[i] && tbl_owner[i] == id) begin
						push_result(STAT_FREED, tbl_start[i], tbl_len[i], id, 1'b0, 1'b0);
						tbl_valid[i] = 1'b0;
						k++;
					end
				if (k == 0)
					push_result(STAT_NOT_FOUND, 0, 0, id, 1'b0, 1'b1);
				else
					results_due[results_due.size()-1].fin = 1'b1;
			end
			OP_LIST: begin
				cnt = build_layout();
				if (cnt == 0)
					push_result(STAT_LIST, 0, 0, '0, 1'b1, 1'b1);
				for (int i = 0; i < cnt; i++)
					push_result(STAT_LIST, map_start[i], map_len[i], map_own[i],
						map_hole[i], i == cnt - 1);
			end
			default: ;
		endcase
	endfunction

	// Compare each result transfer first, then take in new requests and writes
	always @(posedge clk or negedge arst_n) begin
		alloc_result_t e;
		if (!arst_n) begin
			errors = 0;
			mem_size = MEM_SIZE_RST;
			results_due.delete();
			for (int i = 0; i < NUM_SEGS; i++) begin
				tbl_valid[i] = 1'b0;
				tbl_owner[i] = '0;
				tbl_start[i] = '0;
				tbl_len[i] = '0;
			end
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: status %0d addr %0d len %0d owner %0h",
						$time, status, address, length, result_owner);
				end else begin
					e = results_due.pop_front();
					if (status !== e.st || address !== e.addr || length !== e.len ||
							result_owner !== e.own || is_hole !== e.hole || last !== e.fin) begin
						errors++;
						$display("%0t: mismatch: expected st %0d addr %0d len %0d own %0h hole %0b last %0b",
							$time, e.st, e.addr, e.len, e.own, e.hole, e.fin);
						$display("%0t:          actual   st %0d addr %0d len %0d own %0h hole %0b last %0b",
							$time, status, address, length, result_owner, is_hole, last);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_request(opcode_t'(opcode), owner_id, request_size);
			if (cfg_wr_en)
				mem_size = cfg_wr_data;
		end
	end

endmodule

// File: tb/tb_worst_fit_segment_allocator.sv
// Testbench top for the worst-fit segment allocator: stimulus, handshake pressure and verdict.
module tb_worst_fit_segment_allocator;
	import wfsa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 400;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        opcode;
	logic [ID_W-1:0]   owner_id;
	logic [ADDR_W-1:0] request_size;
	logic              cfg_wr_en;
	logic [ADDR_W-1:0] cfg_wr_data;
	logic              out_valid;
	logic              out_stall;
	logic [2:0]        status;
	logic [ADDR_W-1:0] address;
	logic [ADDR_W-1:0] length;
	logic [ID_W-1:0]   result_owner;
	logic              is_hole;
	logic              last;
	int                errors;
	int                pending;
	int                idle_pct;
	int                stall_pct;
	logic [ID_W-1:0]   owners [6];
	logic [ADDR_W-1:0] cur_size;

	worst_fit_segment_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .owner_id(owner_id), .request_size(request_size),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .address(address), .length(length),
		.result_owner(result_owner), .is_hole(is_hole), .last(last)
	);

	wfsa_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .owner_id(owner_id), .request_size(request_size),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .address(address), .length(length),
		.result_owner(result_owner), .is_hole(is_hole), .last(last),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Random receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Hold one request until it transfers, with random gaps ahead of it
	task automatic send_req(opcode_t op, logic [ID_W-1:0] id, logic [ADDR_W-1:0] sz);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		owner_id <= id;
		request_size <= sz;
		do @(posedge clk); while (in_stall);
	endtask

	// Drain every result, let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(logic [ADDR_W-1:0] v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		cur_size = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Mostly allocations and frees over a small owner pool, some lists and noise
	task automatic random_req();
		int pick;
		logic [ID_W-1:0] id;
		logic [ADDR_W-1:0] sz;
		pick = $urandom_range(99);
		id = ($urandom_range(9) == 0) ? ID_W'($urandom) : owners[$urandom_range(5)];
		case ($urandom_range(19))
			0: sz = '0;
			1: sz = ADDR_W'($urandom);
			default: sz = ADDR_W'($urandom_range(1, int'(cur_size) / 6 + 1));
		endcase
		if (pick < 48)
			send_req(OP_ALLOC, id, sz);
		else if (pick < 75)
			send_req(OP_FREE, id, sz);
		else if (pick < 95)
			send_req(OP_LIST, id, sz);
		else
			send_req(OP_RSVD, id, sz);
	endtask

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_ALLOC;
		owner_id <= '0;
		request_size <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		idle_pct = 0;
		stall_pct = 0;
		cur_size = MEM_SIZE_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero size, no space, placement, multi-segment free, unused opcode
		send_req(OP_LIST, 16'h0000, 16'h0000);
		send_req(OP_ALLOC, 16'h0000, 16'h0000);
		send_req(OP_ALLOC, 16'hFFFF, 16'hFFFF);
		send_req(OP_ALLOC, 16'h0001, 16'd100);
		send_req(OP_ALLOC, 16'hFFFF, 16'd200);
		send_req(OP_ALLOC, 16'h0001, 16'd50);
		send_req(OP_FREE, 16'h1234, 16'h0000);
		send_req(OP_LIST, 16'h0000, 16'h0000);
		send_req(OP_FREE, 16'h0001, 16'h0000);
		send_req(OP_RSVD, 16'h0001, 16'h0010);
		send_req(OP_FREE, 16'hFFFF, 16'h0000);
		// Fill the table exactly, then hit table full
		for (int i = 0; i < NUM_SEGS; i++)
			send_req(OP_ALLOC, (i % 2) ? 16'h5500 : 16'h00AA, 16'd64);
		send_req(OP_ALLOC, 16'h0002, 16'd1);
		send_req(OP_LIST, 16'h0000, 16'h0000);
		// Shrink below live segments, then empty the table
		write_size(16'd512);
		send_req(OP_LIST, 16'h0000, 16'h0000);
		send_req(OP_FREE, 16'h00AA, 16'h0000);
		send_req(OP_LIST, 16'h0000, 16'h0000);
		send_req(OP_FREE, 16'h5500, 16'h0000);
		write_size(16'd0);
		send_req(OP_LIST, 16'h0000, 16'h0000);
		send_req(OP_ALLOC, 16'h0003, 16'd1);
		write_size(16'd1);
		send_req(OP_ALLOC, 16'h0004, 16'd1);
		send_req(OP_ALLOC, 16'h0005, 16'd1);
		send_req(OP_LIST, 16'h0000, 16'h0000);

		// Random phases under varying pressure and memory sizes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  write_size(16'hFFFF); end
				1: begin idle_pct = 56; stall_pct = 0;  write_size(16'd1024); end
				2: begin idle_pct = 0;  stall_pct = 56; write_size(ADDR_W'($urandom)); end
				default: begin idle_pct = 30; stall_pct = 30; write_size(16'd200); end
			endcase
			foreach (owners[i])
				owners[i] = ID_W'($urandom);
			for (int n = 0; n < 30; n++)
				random_req();
		end

		drain();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
